FILE: sv/wsc_pkg.sv
`default_nettype none

package wsc_pkg;

  // Build-time defaults for the top-level parameters.
  localparam int GRID_MAX_DEF     = 256;
  localparam int MAX_WORD_LEN_DEF = 4;

  // Fixed field widths.
  localparam int WORD_REGS   = 4;
  localparam int CHAR_W      = 8;
  localparam int TOTAL_W     = 32;
  localparam int ROW_WIDTH_W = 9;
  localparam int WORD_LEN_W  = 3;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 9;
  localparam int HITS_W      = 4;

  // Register values after reset.
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST   = 9'd256;
  localparam logic [WORD_LEN_W-1:0]  WORD_LENGTH_RST = 3'd4;
  localparam logic [CHAR_W-1:0]      CHAR_FIRST_RST  = 8'd88;
  localparam logic [CHAR_W-1:0]      CHAR_SECOND_RST = 8'd77;
  localparam logic [CHAR_W-1:0]      CHAR_THIRD_RST  = 8'd65;
  localparam logic [CHAR_W-1:0]      CHAR_FOURTH_RST = 8'd83;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROW_WIDTH   = 3'd0,
    REG_WORD_LENGTH = 3'd1,
    REG_CHAR_FIRST  = 3'd2,
    REG_CHAR_SECOND = 3'd3,
    REG_CHAR_THIRD  = 3'd4,
    REG_CHAR_FOURTH = 3'd5
  } cfg_reg_t;

  // Controls shared by every window cell.
  typedef struct packed {
    logic advance;
    logic load;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/grid_word_search_counter.sv
// Word search counter over a character grid streamed in raster order.
// Input stream: one grid cell per beat, s_axis_tdata[7:0] is the character
// and s_axis_tlast marks the final cell of the grid. Rows are row_width
// characters wide; a grid may end in the middle of a row.
// Output stream: one beat per grid, m_axis_tdata[31:0] is the number of
// occurrences of the configured word in all eight directions, saturating.
// Configuration: cfg_valid/cfg_index/cfg_data write one register per beat
// (0 row width, 1 word length, 2..5 word characters); cfg_ready is always
// high. Writing the row width restarts the current grid.
// Throughput is one cell per clock. A row of window cells holding the three
// rows above slides one column per beat, fed from a line memory read ahead
// of the current column; the total of a grid is registered into the output
// register, or into the skid slot while the output waits. An output register
// plus one skid slot lets the block keep taking cells while a total waits;
// s_axis_tready drops only when both hold a total. Reset restores the
// register defaults and clears the counters; the line memory needs no
// clearing, since rows are read only after being written in the same grid.
`default_nettype none

module grid_word_search_counter #(
  parameter int GRID_MAX     = wsc_pkg::GRID_MAX_DEF,
  parameter int MAX_WORD_LEN = wsc_pkg::MAX_WORD_LEN_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Input beats.
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [7:0]                      s_axis_tdata,  // [7:0] cell_char
  input  wire logic                            s_axis_tlast,  // grid_end
  // Result beats.
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [31:0]                          m_axis_tdata,  // [31:0] match_total
  // Register writes.
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [wsc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [wsc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import wsc_pkg::*;

  localparam int LEN_CAP = (MAX_WORD_LEN < WORD_REGS) ? MAX_WORD_LEN : WORD_REGS;
  localparam int D       = (LEN_CAP > 1) ? LEN_CAP - 1 : 1;
  localparam int NCELL   = 2 * D + 1;
  localparam int WORD_W  = CHAR_W * D;
  localparam int CW      = $clog2(GRID_MAX);
  localparam int WW      = $clog2(GRID_MAX + 1);
  localparam int AW      = WW + 1;
  localparam int EXW     = (WW > ROW_WIDTH_W) ? WW : ROW_WIDTH_W;
  localparam int RSW     = $clog2(D + 1);
  localparam int NHEAD   = D + 2;

  // Configuration registers.
  logic [ROW_WIDTH_W-1:0] row_width;
  logic [WORD_LEN_W-1:0]  word_length;
  logic [CHAR_W-1:0]      word_char [WORD_REGS];

  // Grid position and count.
  logic [CW-1:0]      col;
  logic [RSW-1:0]     rows_seen;
  logic [TOTAL_W-1:0] total;
  logic [CHAR_W-1:0]  row_bytes [D];

  // Column words written at the head of the current row.
  logic [WORD_W-1:0] head [NHEAD];
  logic [WORD_W-1:0] head_next [D+1];

  // Window and line memory.
  logic [WORD_W-1:0] win [NCELL];
  logic [WORD_W-1:0] new_word;
  logic [WORD_W-1:0] tail_word;
  logic [WORD_W-1:0] rd_data;
  logic [WORD_W+CHAR_W-1:0] push_word;
  logic [AW-1:0]     rd_addr_x;
  logic              rd_en;
  cell_ctrl_t        cell_ctrl;

  // Output register and skid slot.
  logic               out_valid;
  logic [TOTAL_W-1:0] out_total;
  logic               skid_valid;
  logic [TOTAL_W-1:0] skid_total;

  logic               s_accept;
  logic               cfg_restart;
  logic [EXW-1:0]     rw_x;
  logic [AW-1:0]      width_x;
  logic [AW-1:0]      col_x;
  logic               end_of_row;
  logic [WORD_LEN_W-1:0] len_eff;
  logic [DEPTH_MASK_W()-1:0] unused_dummy;
  logic [D-1:0]       ok_mask [4];
  logic [HITS_W-1:0]  hits;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] res_total;
  logic               res_valid;

  function automatic int DEPTH_MASK_W();
    return 1;
  endfunction

  assign unused_dummy = '0;

  // Handshakes.
  assign s_axis_tready = !skid_valid;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign cfg_restart   = cfg_valid && (cfg_reg_t'(cfg_index) == REG_ROW_WIDTH);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_total;

  // Effective row width and word length.
  always_comb begin
    rw_x = EXW'(row_width);
    if (rw_x == '0) begin
      width_x = AW'(1);
    end else if (rw_x > EXW'(GRID_MAX)) begin
      width_x = AW'(GRID_MAX);
    end else begin
      width_x = AW'(rw_x);
    end
    if (word_length == '0) begin
      len_eff = WORD_LEN_W'(1);
    end else if (word_length > WORD_LEN_W'(LEN_CAP)) begin
      len_eff = WORD_LEN_W'(LEN_CAP);
    end else begin
      len_eff = word_length;
    end
  end

  assign col_x      = AW'(col);
  assign end_of_row = (col_x + AW'(1)) == width_x;

  // Which cells k steps back lie inside the grid.
  for (genvar k = 1; k <= D; k++) begin : g_mask
    assign ok_mask[0][k-1] = col_x >= AW'(k);
    assign ok_mask[1][k-1] = rows_seen >= RSW'(k);
    assign ok_mask[2][k-1] = (rows_seen >= RSW'(k)) && (col_x >= AW'(k));
    assign ok_mask[3][k-1] = (rows_seen >= RSW'(k)) && ((col_x + AW'(k)) < width_x);
  end

  wsc_match #(
    .DEPTH   (D),
    .LEN_CAP (LEN_CAP)
  ) u_match (
    .cur       (s_axis_tdata),
    .win       (win),
    .row_bytes (row_bytes),
    .ok_mask   (ok_mask),
    .len       (len_eff),
    .word_char (word_char),
    .hits      (hits)
  );

  // Saturating running total including this cell.
  assign sum       = {1'b0, total} + (TOTAL_W + 1)'(hits);
  assign res_total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
  assign res_valid = s_accept && s_axis_tlast;

  // New column word: this cell on top, older rows pushed down.
  assign push_word = {win[D], s_axis_tdata};
  assign new_word  = push_word[WORD_W-1:0];

  always_comb begin
    for (int j = 0; j <= D; j++) begin
      head_next[j] = (s_accept && col_x == AW'(j)) ? new_word : head[j];
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NHEAD; j++) begin
      if (s_accept && col_x == AW'(j)) begin
        head[j] <= new_word;
      end
    end
  end

  // Read ahead so the rightmost cell has its column ready on the next beat.
  assign rd_addr_x = col_x + AW'(D + 2);
  assign rd_en     = s_accept && (rd_addr_x < AW'(GRID_MAX));

  wsc_line_mem #(
    .DEPTH  (GRID_MAX),
    .WORD_W (WORD_W),
    .ADDR_W (CW)
  ) u_line_mem (
    .clk     (clk),
    .wr_en   (s_accept),
    .wr_addr (col),
    .wr_data (new_word),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_x[CW-1:0]),
    .rd_data (rd_data)
  );

  // Window cells; at a row change the right half reloads from the head words.
  assign cell_ctrl.advance = s_accept;
  assign cell_ctrl.load    = end_of_row;
  assign tail_word         = (col == '0) ? head[D+1] : rd_data;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    logic [WORD_W-1:0] load_word;
    logic [WORD_W-1:0] shift_word;
    if (i == NCELL - 1) begin : g_tail
      assign shift_word = tail_word;
    end else begin : g_mid
      assign shift_word = win[i+1];
    end
    if (i >= D) begin : g_load
      assign load_word = head_next[i-D];
    end else begin : g_keep
      assign load_word = shift_word;
    end
    wsc_col_cell #(
      .WORD_W (WORD_W)
    ) u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .load_word  (load_word),
      .shift_word (shift_word),
      .word       (win[i])
    );
  end

  // Earlier cells of the current row.
  always_ff @(posedge clk) begin
    if (s_accept) begin
      row_bytes[0] <= s_axis_tdata;
      for (int k = 1; k < D; k++) begin
        row_bytes[k] <= row_bytes[k-1];
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_width    <= ROW_WIDTH_RST;
      word_length  <= WORD_LENGTH_RST;
      word_char[0] <= CHAR_FIRST_RST;
      word_char[1] <= CHAR_SECOND_RST;
      word_char[2] <= CHAR_THIRD_RST;
      word_char[3] <= CHAR_FOURTH_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ROW_WIDTH:   row_width    <= cfg_data[ROW_WIDTH_W-1:0];
        REG_WORD_LENGTH: word_length  <= cfg_data[WORD_LEN_W-1:0];
        REG_CHAR_FIRST:  word_char[0] <= cfg_data[CHAR_W-1:0];
        REG_CHAR_SECOND: word_char[1] <= cfg_data[CHAR_W-1:0];
        REG_CHAR_THIRD:  word_char[2] <= cfg_data[CHAR_W-1:0];
        REG_CHAR_FOURTH: word_char[3] <= cfg_data[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  // Grid position, rows seen and running total.
  always_ff @(posedge clk) begin
    if (rst || cfg_restart) begin
      col       <= '0;
      rows_seen <= '0;
      total     <= '0;
    end else if (s_accept) begin
      if (s_axis_tlast) begin
        col       <= '0;
        rows_seen <= '0;
        total     <= '0;
      end else begin
        total <= res_total;
        if (end_of_row) begin
          col <= '0;
          if (rows_seen < RSW'(D)) begin
            rows_seen <= rows_seen + RSW'(1);
          end
        end else begin
          col <= CW'(col_x + AW'(1));
        end
      end
    end
  end

  // Output register with one skid slot behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_axis_tready) begin
      out_total <= skid_valid ? skid_total : res_total;
    end else if (res_valid) begin
      skid_total <= res_total;
    end
  end

endmodule

`default_nettype wire

FILE: sv/wsc_line_mem.sv
`default_nettype none

module wsc_line_mem #(
  parameter int DEPTH  = 256,
  parameter int WORD_W = 24,
  parameter int ADDR_W = 8
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WORD_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [DEPTH];

  // One write port, one read port with registered data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/wsc_col_cell.sv
`default_nettype none

module wsc_col_cell #(
  parameter int WORD_W = 24
) (
  input  wire logic                clk,
  input  wire wsc_pkg::cell_ctrl_t ctrl,
  input  wire logic [WORD_W-1:0]   load_word,
  input  wire logic [WORD_W-1:0]   shift_word,
  output logic      [WORD_W-1:0]   word
);

  import wsc_pkg::*;

  // One column of the rows above: takes its right neighbor on every beat,
  // or a fresh column at the start of a row.
  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      word <= ctrl.load ? load_word : shift_word;
    end
  end

endmodule

`default_nettype wire

FILE: sv/wsc_match.sv
`default_nettype none

module wsc_match #(
  parameter int DEPTH   = 3,
  parameter int LEN_CAP = 4
) (
  input  wire logic [wsc_pkg::CHAR_W-1:0]         cur,
  input  wire logic [wsc_pkg::CHAR_W*DEPTH-1:0]   win [2*DEPTH+1],
  input  wire logic [wsc_pkg::CHAR_W-1:0]         row_bytes [DEPTH],
  input  wire logic [DEPTH-1:0]                   ok_mask [4],
  input  wire logic [wsc_pkg::WORD_LEN_W-1:0]     len,
  input  wire logic [wsc_pkg::CHAR_W-1:0]         word_char [wsc_pkg::WORD_REGS],
  output logic      [wsc_pkg::HITS_W-1:0]         hits
);

  import wsc_pkg::*;

  logic [CHAR_W-1:0] seq [4][LEN_CAP];
  logic              dir_ok;
  logic              fwd;
  logic              rev;

  // Gather the cells k steps back along row, column, up-left and up-right.
  always_comb begin
    for (int d = 0; d < 4; d++) begin
      seq[d][0] = cur;
    end
    for (int k = 1; k < LEN_CAP; k++) begin
      seq[0][k] = row_bytes[k-1];
      seq[1][k] = win[DEPTH][CHAR_W*(k-1) +: CHAR_W];
      seq[2][k] = win[DEPTH-k][CHAR_W*(k-1) +: CHAR_W];
      seq[3][k] = win[DEPTH+k][CHAR_W*(k-1) +: CHAR_W];
    end
  end

  // Compare each line both ways and add up the hits.
  always_comb begin
    hits   = '0;
    dir_ok = 1'b0;
    fwd    = 1'b0;
    rev    = 1'b0;
    for (int d = 0; d < 4; d++) begin
      dir_ok = 1'b1;
      fwd    = 1'b1;
      rev    = 1'b1;
      for (int k = 1; k < LEN_CAP; k++) begin
        if (k < int'(len) && !ok_mask[d][k-1]) begin
          dir_ok = 1'b0;
        end
      end
      for (int i = 0; i < LEN_CAP; i++) begin
        if (i < int'(len) && seq[d][i] != word_char[i]) begin
          rev = 1'b0;
        end
        for (int j = 0; j < LEN_CAP; j++) begin
          if (i + j + 1 == int'(len) && seq[d][j] != word_char[i]) begin
            fwd = 1'b0;
          end
        end
      end
      if (dir_ok) begin
        hits = hits + HITS_W'(fwd) + HITS_W'(rev);
      end
    end
  end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import wsc_pkg::*;

  // Rows held above the current one, and the widest row the block keeps.
  localparam int WINDOW       = MAX_WORD_LEN_DEF - 1;
  localparam int ROW_SLOTS    = GRID_MAX_DEF;
  localparam int CELL_TARGET  = 1800;
  localparam int DRAIN_CYCLES = 8;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int PRINT_CAP    = 50;

  // Register indexes that the block does not decode.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LOW  = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HIGH = 3'd7;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Line directions that end at the current cell.
  localparam int DIR_ROW    = 0;
  localparam int DIR_COLUMN = 1;
  localparam int DIR_DIAG   = 2;
  localparam int DIR_ANTI   = 3;

  typedef enum logic {STEP_CELL, STEP_WRITE} step_kind_t;

  typedef struct packed {
    step_kind_t               kind;
    logic [CFG_INDEX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]    val;
    logic                     last;
    logic                     known;
    logic [TOTAL_W-1:0]       total;
  } plan_step_t;

  function automatic plan_step_t cell_step(input logic [CHAR_W-1:0] ch, input logic last);
    return '{kind: STEP_CELL, idx: '0, val: {1'b0, ch}, last: last, known: 1'b0,
             total: '0};
  endfunction

  // Final cell of a grid whose total is obvious by inspection.
  function automatic plan_step_t cell_known(input logic [CHAR_W-1:0] ch,
                                            input logic [TOTAL_W-1:0] total);
    return '{kind: STEP_CELL, idx: '0, val: {1'b0, ch}, last: 1'b1, known: 1'b1,
             total: total};
  endfunction

  function automatic plan_step_t reg_step(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
    return '{kind: STEP_WRITE, idx: idx, val: data, last: 1'b0, known: 1'b0, total: '0};
  endfunction

  localparam int PLAN_LEN = 39;
  localparam plan_step_t PLAN [PLAN_LEN] = '{
    // Default word after reset, forward and backward along a row.
    cell_step("X", 1'b0), cell_step("M", 1'b0), cell_step("A", 1'b0),
    cell_known("S", 32'd1),
    cell_step("S", 1'b0), cell_step("A", 1'b0), cell_step("M", 1'b0),
    cell_known("X", 32'd1),
    // Zero word length acts as one: a single cell hits in all eight directions.
    reg_step(REG_WORD_LENGTH, 9'd0), reg_step(REG_CHAR_FIRST, 9'h1FF),
    cell_known(8'hFF, 32'd8), cell_known(8'h00, 32'd0),
    // Zero row width acts as one: the word stands in a single column.
    reg_step(REG_ROW_WIDTH, 9'd0), reg_step(REG_WORD_LENGTH, 9'd7),
    reg_step(REG_CHAR_FIRST, 9'(8'("X"))),
    cell_step("X", 1'b0), cell_step("M", 1'b0), cell_step("A", 1'b0),
    cell_known("S", 32'd1),
    // Oversized row width, then a write to an index that is not decoded.
    reg_step(REG_ROW_WIDTH, 9'd511), reg_step(REG_SPARE_LOW, 9'h1FF),
    cell_step("S", 1'b0), cell_step("A", 1'b0), cell_step("M", 1'b0),
    cell_known("X", 32'd1),
    // Palindrome on a narrow grid that ends in the middle of its last row.
    reg_step(REG_ROW_WIDTH, 9'd3), reg_step(REG_WORD_LENGTH, 9'd3),
    reg_step(REG_CHAR_FIRST, 9'(8'("A"))), reg_step(REG_CHAR_SECOND, 9'(8'("B"))),
    reg_step(REG_CHAR_THIRD, 9'(8'("A"))), reg_step(REG_CHAR_FOURTH, 9'd0),
    cell_step("A", 1'b0), cell_step("B", 1'b0), cell_step("A", 1'b0),
    cell_step("B", 1'b0), cell_step("B", 1'b0), cell_step("B", 1'b0),
    cell_step("A", 1'b0), cell_step("B", 1'b1)
  };

  localparam logic [CFG_INDEX_W-1:0] CHAR_REGS [WORD_REGS] = '{
    REG_CHAR_FIRST, REG_CHAR_SECOND, REG_CHAR_THIRD, REG_CHAR_FOURTH
  };

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata  = '0;
  logic                   s_axis_tlast  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [31:0]            m_axis_tdata;
  logic                   cfg_valid     = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index     = REG_ROW_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data      = '0;

  grid_word_search_counter u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Shadow of the search state: rows above, recent cells of this row, counters.
  logic [CHAR_W-1:0]      above [WINDOW][ROW_SLOTS];
  logic [CHAR_W-1:0]      recent [WINDOW];
  int                     next_col  = 0;
  int                     rows_done = 0;
  logic [TOTAL_W-1:0]     grid_total = '0;
  logic [ROW_WIDTH_W-1:0] cfg_width  = ROW_WIDTH_RST;
  logic [WORD_LEN_W-1:0]  cfg_len    = WORD_LENGTH_RST;
  logic [CHAR_W-1:0]      word [WORD_REGS] = '{CHAR_FIRST_RST, CHAR_SECOND_RST,
                                               CHAR_THIRD_RST, CHAR_FOURTH_RST};

  logic [TOTAL_W-1:0] totals_due [$];
  logic [TOTAL_W-1:0] due_total;
  int                 mismatches = 0;
  int                 cells_sent = 0;
  int                 burst_left = 0;
  logic [5:0]         stall_count = '0;
  int                 stall_mode  = 0;

  function automatic int active_width();
    int w;
    w = int'(cfg_width);
    if (w < 1) w = 1;
    if (w > GRID_MAX_DEF) w = GRID_MAX_DEF;
    return w;
  endfunction

  function automatic int active_len();
    int n;
    n = int'(cfg_len);
    if (n < 1) n = 1;
    if (n > MAX_WORD_LEN_DEF) n = MAX_WORD_LEN_DEF;
    if (n > WORD_REGS) n = WORD_REGS;
    return n;
  endfunction

  function automatic void restart_grid();
    next_col   = 0;
    rows_done  = 0;
    grid_total = '0;
  endfunction

  // Newest row goes to slot 0 of the column, older ones move down.
  function automatic void shift_in_column(input int x, input logic [CHAR_W-1:0] v);
    if (x >= ROW_SLOTS) return;
    for (int k = WINDOW - 1; k > 0; k--) above[k][x] = above[k-1][x];
    above[0][x] = v;
  endfunction

  // Cell k steps back along a direction; 0 if that cell is outside the grid.
  function automatic bit look_back(input int dir, input int k, input int col, input int w,
                                   output logic [CHAR_W-1:0] v);
    v = '0;
    case (dir)
      DIR_ROW: begin
        if (col < k) return 1'b0;
        v = recent[k-1];
      end
      DIR_COLUMN: begin
        if (rows_done < k) return 1'b0;
        v = above[k-1][col];
      end
      DIR_DIAG: begin
        if (rows_done < k || col < k) return 1'b0;
        v = above[k-1][col-k];
      end
      default: begin
        if (rows_done < k || col + k >= w) return 1'b0;
        v = above[k-1][col+k];
      end
    endcase
    return 1'b1;
  endfunction

  // Forward and backward hits of the word on the four lines ending at this cell.
  function automatic int hits_ending_at(input logic [CHAR_W-1:0] ch, input int col,
                                        input int w);
    int                len;
    int                hits;
    logic [CHAR_W-1:0] seq [WORD_REGS];
    bit                ok;
    bit                fwd;
    bit                rev;
    len  = active_len();
    hits = 0;
    for (int d = DIR_ROW; d <= DIR_ANTI; d++) begin
      ok  = 1'b1;
      fwd = 1'b1;
      rev = 1'b1;
      seq[len-1] = ch;
      for (int i = 1; i < len; i++) begin
        if (!look_back(d, i, col, w, seq[len-1-i])) ok = 1'b0;
      end
      if (ok) begin
        for (int i = 0; i < len; i++) begin
          if (seq[i] != word[i]) fwd = 1'b0;
          if (seq[len-1-i] != word[i]) rev = 1'b0;
        end
        hits += int'(fwd) + int'(rev);
      end
    end
    return hits;
  endfunction

  // Takes one cell; returns 1 with the grid total when the cell ends a grid.
  function automatic bit scan_cell(input logic [CHAR_W-1:0] ch, input logic last,
                                   output logic [TOTAL_W-1:0] total);
    int           w;
    int           col;
    logic [32:0]  sum;
    w   = active_width();
    col = next_col;
    if (col >= w) col = w - 1;
    sum = {1'b0, grid_total} + 33'(hits_ending_at(ch, col, w));
    grid_total = sum[32] ? TOTAL_MAX : sum[31:0];

    if (col >= WINDOW) shift_in_column(col - WINDOW, recent[WINDOW-1]);
    if (col + 1 >= w) begin
      // End of row: flush the columns still held in the row window.
      for (int j = WINDOW - 1; j >= 1; j--) begin
        if (col >= j) shift_in_column(col - j, recent[j-1]);
      end
      shift_in_column(col, ch);
      if (rows_done < WINDOW) rows_done++;
      next_col = 0;
    end else begin
      for (int j = WINDOW - 1; j > 0; j--) recent[j] = recent[j-1];
      recent[0] = ch;
      next_col = col + 1;
    end

    total = grid_total;
    if (last) restart_grid();
    return last;
  endfunction

  function automatic void apply_write(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_ROW_WIDTH: begin
        cfg_width = data[ROW_WIDTH_W-1:0];
        restart_grid();
      end
      REG_WORD_LENGTH: cfg_len = data[WORD_LEN_W-1:0];
      REG_CHAR_FIRST:  word[0] = data[CHAR_W-1:0];
      REG_CHAR_SECOND: word[1] = data[CHAR_W-1:0];
      REG_CHAR_THIRD:  word[2] = data[CHAR_W-1:0];
      REG_CHAR_FOURTH: word[3] = data[CHAR_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_width();
    case ($urandom_range(0, 19))
      0:       return 9'd0;
      1:       return 9'd511;
      2:       return 9'd256;
      3:       return 9'd255;
      4:       return 9'($urandom_range(257, 511));
      5, 6:    return 9'($urandom_range(9, 254));
      default: return 9'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_len();
    case ($urandom_range(0, 9))
      0:       return 9'd0;
      1:       return 9'($urandom_range(5, 7));
      default: return 9'($urandom_range(1, 4));
    endcase
  endfunction

  // Word characters come mostly from the alphabet of the grid, so words do occur.
  function automatic logic [CFG_DATA_W-1:0] pick_word_char(input logic [CHAR_W-1:0] base,
                                                           input int span);
    logic [CHAR_W-1:0] ch;
    case ($urandom_range(0, 11))
      0:       ch = 8'h00;
      1:       ch = 8'hFF;
      2:       ch = 8'($urandom_range(0, 255));
      default: ch = base + 8'($urandom_range(0, span - 1));
    endcase
    return {1'($urandom_range(0, 1)), ch};
  endfunction

  task automatic report_mismatch(input string what, input logic [TOTAL_W-1:0] got,
                                 input logic [TOTAL_W-1:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("ERROR %0t ns: %s: match_total got %0d, expected %0d", $time, what, got, want);
  endtask

  // One input beat, after a random gap whenever a burst has run out.
  task automatic send_cell(input logic [CHAR_W-1:0] ch, input logic last, input logic known,
                           input logic [TOTAL_W-1:0] known_total);
    logic [TOTAL_W-1:0] total;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    if (scan_cell(ch, last, total)) totals_due.push_back(known ? known_total : total);
    cells_sent++;
  endtask

  // Valid stays high so that writes can follow back to back.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_write(idx, data);
  endtask

  // Stop sending, collect every pending total and let the pipeline empty.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (totals_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result beats are checked here; the receiver stalls on a pattern that
  // changes whenever stall_count wraps around.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_count   <= '0;
      stall_mode    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (totals_due.size() == 0) begin
          report_mismatch("result beat with no grid pending", m_axis_tdata, '0);
        end else begin
          due_total = totals_due.pop_front();
          if (m_axis_tdata !== due_total)
            report_mismatch("wrong grid total", m_axis_tdata, due_total);
        end
      end
      stall_count <= stall_count + 1'b1;
      if (&stall_count) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 2) != 0);
        2:       m_axis_tready <= (stall_count[1:0] == 2'd0);
        default: m_axis_tready <= (stall_count[4:3] == 2'd0);
      endcase
    end
  end

  initial begin
    #(8 * LIMIT_CYCLES);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic              prev_write;
    logic [CHAR_W-1:0] alpha_base;
    int                alpha_span;
    int                phase;
    int                grids;
    int                ncell;
    int                cap;
    logic              open_end;
    logic [CHAR_W-1:0] ch;

    prev_write = 1'b0;
    alpha_base = "A";
    alpha_span = 2;
    phase      = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table; writes wait for the block to go idle.
    foreach (PLAN[n]) begin
      if (PLAN[n].kind == STEP_WRITE) begin
        if (!prev_write) settle();
        write_reg(PLAN[n].idx, PLAN[n].val);
      end else begin
        if (prev_write) cfg_valid <= 1'b0;
        send_cell(PLAN[n].val[CHAR_W-1:0], PLAN[n].last, PLAN[n].known, PLAN[n].total);
      end
      prev_write = (PLAN[n].kind == STEP_WRITE);
    end

    // Random phases: new settings while idle, then a few grids.
    while (cells_sent < CELL_TARGET) begin
      settle();
      if ($urandom_range(0, 3) != 0) write_reg(REG_ROW_WIDTH, pick_width());
      if ($urandom_range(0, 1) == 1) write_reg(REG_WORD_LENGTH, pick_len());
      if (phase == 0 || $urandom_range(0, 1) == 1) begin
        alpha_base = 8'($urandom_range(0, 255));
        alpha_span = $urandom_range(2, 4);
        foreach (CHAR_REGS[i]) write_reg(CHAR_REGS[i], pick_word_char(alpha_base, alpha_span));
      end
      if ($urandom_range(0, 9) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_HIGH : REG_SPARE_LOW,
                  9'($urandom_range(0, 511)));
      cfg_valid <= 1'b0;

      grids = $urandom_range(1, 3);
      for (int g = 0; g < grids; g++) begin
        cap   = ($urandom_range(0, 7) == 0) ? 1100 : 120;
        ncell = active_width() * $urandom_range(1, 5);
        if (ncell > cap) ncell = $urandom_range(1, cap);
        if ($urandom_range(0, 3) == 0) ncell = $urandom_range(1, ncell);
        // Now and then the phase stops with the grid still open.
        open_end = (g == grids - 1) && ($urandom_range(0, 7) == 0);
        for (int c = 0; c < ncell; c++) begin
          if ($urandom_range(0, 7) == 0) ch = 8'($urandom_range(0, 255));
          else ch = alpha_base + 8'($urandom_range(0, alpha_span - 1));
          send_cell(ch, (c == ncell - 1) && !open_end, 1'b0, '0);
        end
      end
      phase++;
    end

    settle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
